[hw/rtl/bmorph_pkg.sv]
// ----------------------------------------------------------------------------
// bmorph_pkg - shared types and window function for 3x3 binary morphology
// Row widths, transfer payload structs, per-cell configuration and the
// 3x3 erosion / dilation kernel on one row word.
// ----------------------------------------------------------------------------
package bmorph_pkg;

	localparam int ROW_W   = 64;
	localparam int WIDTH_W = 7;
	localparam int MODE_W  = 2;

	// morph_mode codes
	localparam logic [MODE_W-1:0] MODE_ERODE  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_DILATE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_OPEN   = 2'd2;
	localparam logic [MODE_W-1:0] MODE_CLOSE  = 2'd3;

	// register indexes
	localparam logic REG_IMAGE_WIDTH = 1'b0;
	localparam logic REG_MORPH_MODE  = 1'b1;

	typedef struct packed {
		logic [ROW_W-1:0] pixel_row;
		logic             last_row;
	} pixel_item_t;

	typedef struct packed {
		logic [ROW_W-1:0] result_row;
		logic             result_last;
	} result_item_t;

	// settings one cell needs
	typedef struct packed {
		logic             erode;
		logic [ROW_W-1:0] mask;
		logic [ROW_W-1:0] interior;
	} cell_cfg_t;

	// 3x3 window on the center row; a missing neighbor row is flagged low
	function automatic logic [ROW_W-1:0] window_op(
		input logic             erode,
		input logic             has_up,
		input logic [ROW_W-1:0] up,
		input logic [ROW_W-1:0] mid,
		input logic             has_down,
		input logic [ROW_W-1:0] down,
		input logic [ROW_W-1:0] mask,
		input logic [ROW_W-1:0] interior
	);
		logic [ROW_W-1:0] u;
		logic [ROW_W-1:0] m;
		logic [ROW_W-1:0] d;
		logic [ROW_W-1:0] r;
		logic [ROW_W-1:0] res;
		u = up & mask;
		m = mid & mask;
		d = down & mask;
		if (erode) begin
			r = u & m & d;
			if (!has_up || !has_down) begin
				res = '0;
			end else begin
				res = r & (r << 1) & (r >> 1) & interior;
			end
		end else begin
			r = m | (has_up ? u : '0) | (has_down ? d : '0);
			res = (r | (r << 1) | (r >> 1)) & mask;
		end
		return res;
	endfunction

endpackage

[hw/rtl/bmorph_cell.sv]
// ----------------------------------------------------------------------------
// bmorph_cell - one 3x3 morphology stage
// Holds the previous and current row, applies the window as each new row
// arrives and queues up to two result rows per transfer in a short queue.
// ----------------------------------------------------------------------------
module bmorph_cell
	import bmorph_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  cell_cfg_t    cfg,
	input  logic         in_valid,
	output logic         in_stall,
	input  result_item_t in_item,
	output logic         out_valid,
	input  logic         out_stall,
	output result_item_t out_item
);

	localparam int QDEPTH = 3;
	localparam int QIDX_W = 2;

	logic [ROW_W-1:0]  prev_q;
	logic [ROW_W-1:0]  cur_q;
	logic [1:0]        held_q;
	result_item_t      queue_q [QDEPTH];
	logic [QIDX_W-1:0] cnt_q;

	logic              accept;
	logic              pop;
	logic [ROW_W-1:0]  row_m;
	logic [1:0]        npush;
	result_item_t      d0;
	result_item_t      d1;
	logic [1:0]        held_d;
	logic              shift_rows;
	result_item_t      queue_d [QDEPTH];
	logic [QIDX_W-1:0] base;
	logic [QIDX_W-1:0] cnt_d;

	// room for two pushes is kept free before a transfer is taken
	assign in_stall  = cnt_q[1];
	assign accept    = in_valid & ~in_stall;
	assign out_valid = (cnt_q != '0);
	assign out_item  = queue_q[0];
	assign pop       = out_valid & ~out_stall;

	// window evaluation for the arriving row
	always_comb begin
		row_m      = in_item.result_row & cfg.mask;
		npush      = 2'd0;
		d0         = '0;
		d1         = '0;
		held_d     = held_q;
		shift_rows = 1'b0;
		if (held_q == 2'd0) begin
			if (in_item.result_last) begin
				npush          = 2'd1;
				d0.result_row  = window_op(cfg.erode, 1'b0, '0, row_m, 1'b0, '0,
					cfg.mask, cfg.interior);
				d0.result_last = 1'b1;
			end else begin
				shift_rows = 1'b1;
				held_d     = 2'd1;
			end
		end else begin
			npush          = 2'd1;
			d0.result_row  = window_op(cfg.erode, held_q[1], prev_q, cur_q, 1'b1, row_m,
				cfg.mask, cfg.interior);
			d0.result_last = 1'b0;
			if (in_item.result_last) begin
				npush          = 2'd2;
				d1.result_row  = window_op(cfg.erode, 1'b1, cur_q, row_m, 1'b0, '0,
					cfg.mask, cfg.interior);
				d1.result_last = 1'b1;
				held_d         = 2'd0;
			end else begin
				shift_rows = 1'b1;
				held_d     = 2'd2;
			end
		end
		if (!accept) begin
			npush = 2'd0;
		end
	end

	// queue: shift out at the head, append behind the remaining entries
	always_comb begin
		for (int i = 0; i < QDEPTH - 1; i++) begin
			queue_d[i] = pop ? queue_q[i+1] : queue_q[i];
		end
		queue_d[QDEPTH-1] = queue_q[QDEPTH-1];
		base = cnt_q - QIDX_W'(pop);
		for (int i = 0; i < QDEPTH; i++) begin
			if (npush != 2'd0 && QIDX_W'(i) == base) begin
				queue_d[i] = d0;
			end
			if (npush == 2'd2 && QIDX_W'(i) == QIDX_W'(base + 2'd1)) begin
				queue_d[i] = d1;
			end
		end
		cnt_d = base + npush;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= 2'd0;
			cnt_q  <= '0;
		end else begin
			cnt_q <= cnt_d;
			if (accept) begin
				held_q <= held_d;
			end
		end
	end

	// row and queue payload
	always_ff @(posedge clk) begin
		if (accept && shift_rows) begin
			prev_q <= cur_q;
			cur_q  <= row_m;
		end
		for (int i = 0; i < QDEPTH; i++) begin
			queue_q[i] <= queue_d[i];
		end
	end

endmodule

[hw/rtl/binary_morphology_3x3.sv]
// ----------------------------------------------------------------------------
// binary_morphology_3x3 - streaming 3x3 binary erosion / dilation
// Two chained morphology cells behind an APB register port.
// ----------------------------------------------------------------------------
// Rows enter as 64-bit words (bit c is column c) at one row per cycle while
// src_stall is low and leave one row later per active stage: erosion and
// dilation use one cell, opening and closing chain two. The last row of a
// frame releases two result rows from a cell, so the source sees a stall at
// frame end while the cell output queues (three entries, taking a new row
// while at most one is held) drain. Registers: image_width at 0x0,
// morph_mode at 0x4; write them only while no frame is in flight.
module binary_morphology_3x3
	import bmorph_pkg::*;
#(
	parameter int MAX_WIDTH = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	input  logic         src_valid,
	output logic         src_stall,
	input  pixel_item_t  src_data,
	output logic         res_valid,
	input  logic         res_stall,
	output result_item_t res_data
);

	logic [WIDTH_W-1:0] image_width_q;
	logic [MODE_W-1:0]  morph_mode_q;
	logic [WIDTH_W-1:0] w_eff;
	logic [ROW_W-1:0]   mask;
	logic [ROW_W-1:0]   interior;
	logic               chain;
	cell_cfg_t          cfg1;
	cell_cfg_t          cfg2;
	result_item_t       s1_in;
	logic               s1_valid;
	logic               s1_stall;
	result_item_t       s1_item;
	logic               s2_in_valid;
	logic               s2_in_stall;
	logic               s2_valid;
	result_item_t       s2_item;

	// register port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q <= WIDTH_W'(64);
			morph_mode_q  <= MODE_ERODE;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_IMAGE_WIDTH: image_width_q <= pwdata[WIDTH_W-1:0];
				REG_MORPH_MODE:  morph_mode_q  <= pwdata[MODE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_IMAGE_WIDTH: prdata = {{(32-WIDTH_W){1'b0}}, image_width_q};
			REG_MORPH_MODE:  prdata = {{(32-MODE_W){1'b0}}, morph_mode_q};
			default:         prdata = '0;
		endcase
	end

	// effective width, row mask and erosion interior columns
	always_comb begin
		w_eff = image_width_q;
		if (w_eff == '0) begin
			w_eff = WIDTH_W'(1);
		end
		if (w_eff > WIDTH_W'(MAX_WIDTH)) begin
			w_eff = WIDTH_W'(MAX_WIDTH);
		end
		mask     = {ROW_W{1'b1}} >> (WIDTH_W'(ROW_W) - w_eff);
		interior = mask & ~ROW_W'(1) & ~(ROW_W'(1) << (w_eff - WIDTH_W'(1)));
	end

	// opening and closing chain both cells; the first erodes in erosion/opening
	assign chain = (morph_mode_q == MODE_OPEN) || (morph_mode_q == MODE_CLOSE);
	assign cfg1  = '{erode: (morph_mode_q == MODE_ERODE) || (morph_mode_q == MODE_OPEN),
		mask: mask, interior: interior};
	assign cfg2  = '{erode: (morph_mode_q == MODE_CLOSE), mask: mask, interior: interior};

	assign s1_in = '{result_row: src_data.pixel_row, result_last: src_data.last_row};

	bmorph_cell u_cell1 (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg1),
		.in_valid  (src_valid),
		.in_stall  (src_stall),
		.in_item   (s1_in),
		.out_valid (s1_valid),
		.out_stall (s1_stall),
		.out_item  (s1_item)
	);

	// route the first cell to the output or into the second cell
	assign s2_in_valid = chain & s1_valid;
	assign s1_stall    = chain ? s2_in_stall : res_stall;

	bmorph_cell u_cell2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg2),
		.in_valid  (s2_in_valid),
		.in_stall  (s2_in_stall),
		.in_item   (s1_item),
		.out_valid (s2_valid),
		.out_stall (res_stall),
		.out_item  (s2_item)
	);

	assign res_valid = chain ? s2_valid : s1_valid;
	assign res_data  = chain ? s2_item : s1_item;

endmodule
